/* rtl/bbd_pkg.sv */
// shared types and constants of the bilinear bayer demosaic core
// no dependencies
`default_nettype none

package bbd_pkg;

  localparam int DEF_MAX_LINE_WIDTH = 512;

  localparam int FRAME_WIDTH_W  = 10;
  localparam int FRAME_HEIGHT_W = 12;
  localparam int ROW_W          = 12;
  localparam int PIX_W          = 8;
  localparam int CFG_INDEX_W    = 4;
  localparam int CFG_DATA_W     = 12;

  localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 10'd320;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 12'd200;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

  // depth of the queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 4;

  // bayer site of the centre pixel, coded as {row odd, column odd}
  typedef enum logic [1:0] {
    SITE_BLUE    = 2'b00,
    SITE_GREEN_B = 2'b01,
    SITE_GREEN_R = 2'b10,
    SITE_RED     = 2'b11
  } site_t;

  // classified 3x3 window around one interior pixel
  typedef struct packed {
    logic [PIX_W-1:0] p_ul;
    logic [PIX_W-1:0] p_u;
    logic [PIX_W-1:0] p_ur;
    logic [PIX_W-1:0] p_l;
    logic [PIX_W-1:0] p_c;
    logic [PIX_W-1:0] p_r;
    logic [PIX_W-1:0] p_dl;
    logic [PIX_W-1:0] p_d;
    logic [PIX_W-1:0] p_dr;
    site_t            site;
    logic             last;
  } win_t;

endpackage

`default_nettype wire

/* rtl/bbd_queue.sv */
// short fifo of classified windows between front and back
// depends on bbd_pkg
`default_nettype none

module bbd_queue import bbd_pkg::*; (
  input  wire  logic                           clk,
  input  wire  logic                           rst,
  input  wire  logic                           wr_en,
  input  wire  win_t                           wr_data,
  input  wire  logic                           rd_en,
  output win_t                                 rd_data,
  output logic                                 q_empty,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     count
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);

  win_t            entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNW-1:0]  fill;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   fill <= fill + CNW'(1);
        2'b01:   fill <= fill - CNW'(1);
        default: fill <= fill;
      endcase
    end
  end

  assign rd_data = entries[rd_ptr];
  assign q_empty = (fill == '0);
  assign count   = fill;

endmodule

`default_nettype wire

/* rtl/bbd_front.sv */
// front: takes raw samples, keeps counters, line stores and the window,
// classifies each interior pixel and pushes its window; depends on bbd_pkg
`default_nettype none

module bbd_front import bbd_pkg::*; #(
  parameter int MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH
) (
  input  wire  logic                                clk,
  input  wire  logic                                rst,
  input  wire  logic                                push,
  input  wire  logic [PIX_W-1:0]                    raw_pixel,
  output logic                                      full,
  input  wire  logic [$clog2(MAX_LINE_WIDTH)-1:0]   width_m1,
  input  wire  logic [ROW_W-1:0]                    height_m1,
  input  wire  logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_count,
  output logic                                      q_push,
  output win_t                                      q_data
);

  localparam int CW  = $clog2(MAX_LINE_WIDTH);
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);

  logic [PIX_W-1:0] upper_store  [MAX_LINE_WIDTH];
  logic [PIX_W-1:0] middle_store [MAX_LINE_WIDTH];
  logic [PIX_W-1:0] top_rd;
  logic [PIX_W-1:0] mid_rd;

  logic [CW-1:0]    column_count;
  logic [ROW_W-1:0] row_count;

  logic             accept;
  logic             emit;
  logic             at_last;

  logic             s1_valid;
  logic             s1_emit;
  site_t            s1_site;
  logic             s1_last;
  logic [PIX_W-1:0] s1_pixel;
  logic [CW-1:0]    s1_idx;

  logic [PIX_W-1:0] win_col [6];

  // credit check: a sample in flight must find room when it reaches the queue
  assign full   = ({1'b0, q_count} + {{CNW{1'b0}}, s1_valid}) >= (CNW+1)'(QUEUE_DEPTH);
  assign accept = push && !full;

  assign emit    = (row_count >= ROW_W'(2)) && (column_count >= CW'(2)) &&
                   (row_count <= height_m1) && (column_count <= width_m1);
  assign at_last = (row_count == height_m1) && (column_count == width_m1);

  // line stores: read before write at the same column
  always_ff @(posedge clk) begin
    top_rd <= upper_store[column_count];
    mid_rd <= middle_store[column_count];
    if (accept) begin
      middle_store[column_count] <= raw_pixel;
    end
    if (s1_valid) begin
      upper_store[s1_idx] <= mid_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (column_count >= width_m1) begin
          column_count <= '0;
          if (row_count >= height_m1) begin
            row_count <= '0;
          end else begin
            row_count <= row_count + ROW_W'(1);
          end
        end else begin
          column_count <= column_count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit  <= emit;
      s1_site  <= site_t'({~row_count[0], ~column_count[0]});
      s1_last  <= at_last;
      s1_pixel <= raw_pixel;
      s1_idx   <= column_count;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win_col[0] <= win_col[3];
      win_col[1] <= win_col[4];
      win_col[2] <= win_col[5];
      win_col[3] <= top_rd;
      win_col[4] <= mid_rd;
      win_col[5] <= s1_pixel;
    end
  end

  assign q_push = s1_valid && s1_emit;

  always_comb begin
    q_data.p_ul = win_col[0];
    q_data.p_l  = win_col[1];
    q_data.p_dl = win_col[2];
    q_data.p_u  = win_col[3];
    q_data.p_c  = win_col[4];
    q_data.p_d  = win_col[5];
    q_data.p_ur = top_rd;
    q_data.p_r  = mid_rd;
    q_data.p_dr = s1_pixel;
    q_data.site = s1_site;
    q_data.last = s1_last;
  end

endmodule

`default_nettype wire

/* rtl/bbd_back.sv */
// back: interpolates blue, green and red from a classified window
// into the result register; depends on bbd_pkg
`default_nettype none

module bbd_back import bbd_pkg::*; (
  input  wire  logic              clk,
  input  wire  logic              rst,
  input  wire  logic              q_empty,
  input  wire  win_t              q_data,
  output logic                    q_pop,
  output logic                    empty,
  input  wire  logic              pop,
  output logic [PIX_W-1:0]        blue,
  output logic [PIX_W-1:0]        green,
  output logic [PIX_W-1:0]        red,
  output logic                    frame_last
);

  logic             out_valid;
  logic [PIX_W+1:0] edge_sum;
  logic [PIX_W+1:0] diag_sum;
  logic [PIX_W:0]   lr_sum;
  logic [PIX_W:0]   ud_sum;
  logic [PIX_W-1:0] edge_avg;
  logic [PIX_W-1:0] diag_avg;
  logic [PIX_W-1:0] lr_avg;
  logic [PIX_W-1:0] ud_avg;
  logic [PIX_W-1:0] blue_next;
  logic [PIX_W-1:0] green_next;
  logic [PIX_W-1:0] red_next;

  assign q_pop = !q_empty && (!out_valid || pop);
  assign empty = !out_valid;

  always_comb begin
    lr_sum   = {1'b0, q_data.p_l} + {1'b0, q_data.p_r};
    ud_sum   = {1'b0, q_data.p_u} + {1'b0, q_data.p_d};
    edge_sum = {1'b0, lr_sum} + {1'b0, ud_sum};
    diag_sum = {2'b0, q_data.p_ul} + {2'b0, q_data.p_ur} +
               {2'b0, q_data.p_dl} + {2'b0, q_data.p_dr};
    lr_avg   = lr_sum[PIX_W:1];
    ud_avg   = ud_sum[PIX_W:1];
    edge_avg = edge_sum[PIX_W+1:2];
    diag_avg = diag_sum[PIX_W+1:2];
  end

  always_comb begin
    unique case (q_data.site)
      SITE_RED: begin
        red_next   = q_data.p_c;
        green_next = edge_avg;
        blue_next  = diag_avg;
      end
      SITE_GREEN_R: begin
        red_next   = lr_avg;
        green_next = q_data.p_c;
        blue_next  = ud_avg;
      end
      SITE_GREEN_B: begin
        red_next   = ud_avg;
        green_next = q_data.p_c;
        blue_next  = lr_avg;
      end
      SITE_BLUE: begin
        red_next   = diag_avg;
        green_next = edge_avg;
        blue_next  = q_data.p_c;
      end
      default: begin
        red_next   = q_data.p_c;
        green_next = q_data.p_c;
        blue_next  = q_data.p_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      blue       <= blue_next;
      green      <= green_next;
      red        <= red_next;
      frame_last <= q_data.last;
    end
  end

endmodule

`default_nettype wire

/* rtl/bayer_bilinear_demosaic_core.sv */
// top level of the bilinear bayer demosaic core: frame size registers,
// front, window queue and back; depends on bbd_pkg, bbd_front, bbd_queue, bbd_back
//
//  channel  | signals                        | transfer when
//  ---------+--------------------------------+--------------------------
//  input    | push, full, raw_pixel          | push && !full
//  result   | pop, empty, blue, green, red,  | pop && !empty
//           | frame_last                     |
//  config   | cfg_valid, cfg_ready,          | cfg_valid && cfg_ready
//           | cfg_index, cfg_data            |
//
// one sample per cycle while full is low; a result is on the result ports after
// the edge that takes the sample completing its window, via the line store read,
// queue write and result register, and later while the result side stalls.
// border samples give no result.
// reset is synchronous and clears counters, queue and result valid; the line
// stores are not cleared. a stalled result side fills the window queue and
// then raises full; configuration writes are always taken.
`default_nettype none

module bayer_bilinear_demosaic_core import bbd_pkg::*; #(
  parameter int MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH
) (
  input  wire  logic                   clk,
  input  wire  logic                   rst,
  input  wire  logic                   push,
  output logic                         full,
  input  wire  logic [PIX_W-1:0]       raw_pixel,
  output logic                         empty,
  input  wire  logic                   pop,
  output logic [PIX_W-1:0]             blue,
  output logic [PIX_W-1:0]             green,
  output logic [PIX_W-1:0]             red,
  output logic                         frame_last,
  input  wire  logic                   cfg_valid,
  output logic                         cfg_ready,
  input  wire  logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW  = $clog2(MAX_LINE_WIDTH);
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);

  logic [FRAME_WIDTH_W-1:0]  frame_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;
  logic [12:0]               width_ext;
  logic [CW-1:0]             width_m1;
  logic [ROW_W-1:0]          height_m1;

  logic                      q_push;
  win_t                      q_wr_data;
  logic                      q_pop;
  win_t                      q_rd_data;
  logic                      q_empty;
  logic [CNW-1:0]            q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= cfg_data[FRAME_WIDTH_W-1:0];
      end else if (cfg_index == REG_FRAME_HEIGHT) begin
        frame_height <= cfg_data[FRAME_HEIGHT_W-1:0];
      end
    end
  end

  // last column and last row of the effective frame size
  always_comb begin
    width_ext = {3'b000, frame_width};
    priority if (width_ext < 13'd3) begin
      width_m1 = CW'(2);
    end else if (width_ext > 13'(MAX_LINE_WIDTH)) begin
      width_m1 = CW'(MAX_LINE_WIDTH - 1);
    end else begin
      width_m1 = CW'(width_ext - 13'd1);
    end
    if (frame_height < 12'd3) begin
      height_m1 = ROW_W'(2);
    end else begin
      height_m1 = frame_height - 12'd1;
    end
  end

  bbd_front #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .raw_pixel (raw_pixel),
    .full      (full),
    .width_m1  (width_m1),
    .height_m1 (height_m1),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  bbd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .q_empty (q_empty),
    .count   (q_count)
  );

  bbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_rd_data),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .blue       (blue),
    .green      (green),
    .red        (red),
    .frame_last (frame_last)
  );

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// testbench of the bilinear bayer demosaic core: a directed table of frames, then random
// frames with size changes, each result checked against a demosaic predictor here or the table
// depends on bbd_pkg and bayer_bilinear_demosaic_core

module tb_top;
  import bbd_pkg::*;

  localparam int CYCLE_LIMIT           = 500000;
  localparam int SETTLE_CYCLES         = 8;
  localparam int TAIL_CYCLES           = 20;
  localparam int RANDOM_ITEMS_PER_MODE = 150;
  localparam int LINE_DEPTH            = DEF_MAX_LINE_WIDTH;
  localparam int DIR_ROWS              = 30;
  localparam int SAT_PROBE_ITEMS       = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = REG_FRAME_HEIGHT + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = '1;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             last;
  } rgb_t;

  typedef struct packed {
    logic                   is_cfg;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    logic [PIX_W-1:0]       pix;
    logic                   typed;
    rgb_t                   rgb;
  } dir_row_t;

  localparam rgb_t NO_RGB    = '0;
  localparam rgb_t WHITE_RGB = '{8'hFF, 8'hFF, 8'hFF, 1'b1};

  // 3x3 frame of full-scale samples, then a 4x4 frame that hits every bayer site
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{1'b1, REG_FRAME_WIDTH,  12'h000, 8'h00, 1'b0, NO_RGB},
    '{1'b1, REG_FRAME_HEIGHT, 12'h001, 8'h00, 1'b0, NO_RGB},
    '{1'b1, REG_UNUSED_LAST,  12'hFFF, 8'h00, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFF, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFF, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFF, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFF, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFF, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFF, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFF, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFF, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFF, 1'b1, WHITE_RGB},
    // upper bits of the width write fall outside the register
    '{1'b1, REG_FRAME_WIDTH,  12'hC04, 8'h00, 1'b0, NO_RGB},
    '{1'b1, REG_FRAME_HEIGHT, 12'h004, 8'h00, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'h01, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFE, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'h02, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFF, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'h80, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'h7F, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'h03, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'h00, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFF, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'h01, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFD, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'h10, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'h00, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'hFF, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'h81, 1'b0, NO_RGB},
    '{1'b0, REG_FRAME_WIDTH,  12'h000, 8'h7E, 1'b0, NO_RGB}
  };

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   push      = 1'b0;
  logic                   full;
  logic [PIX_W-1:0]       raw_pixel = '0;
  logic                   empty;
  logic                   pop       = 1'b0;
  logic [PIX_W-1:0]       blue;
  logic [PIX_W-1:0]       green;
  logic [PIX_W-1:0]       red;
  logic                   frame_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int cycle_count    = 0;
  int mismatch_count = 0;
  int random_sent    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  rgb_t expected_rgb [$];

  // demosaic predictor state
  logic [FRAME_WIDTH_W-1:0]  width_reg;
  logic [FRAME_HEIGHT_W-1:0] height_reg;
  logic [PIX_W-1:0]          upper_line [LINE_DEPTH];
  logic [PIX_W-1:0]          middle_line [LINE_DEPTH];
  logic [PIX_W-1:0]          win_col [6];
  int unsigned               col_pos;
  int unsigned               row_pos;

  bayer_bilinear_demosaic_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .raw_pixel (raw_pixel),
    .empty     (empty),
    .pop       (pop),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .frame_last(frame_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned line_len();
    int unsigned w;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int unsigned frame_rows();
    int unsigned h;
    h = height_reg;
    if (h < 3) h = 3;
    return h;
  endfunction

  function automatic void write_size_reg(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_FRAME_WIDTH) width_reg = data[FRAME_WIDTH_W-1:0];
    else if (idx == REG_FRAME_HEIGHT) height_reg = data[FRAME_HEIGHT_W-1:0];
  endfunction

  // advance the window by one sample; returns 1 when an interior pixel completes
  function automatic bit demosaic_pixel(input logic [PIX_W-1:0] pix, output rgb_t rgb);
    int unsigned w, h, c, r, idx;
    int unsigned p [3][3];
    int unsigned edge_mean, diag_mean, red_v, green_v, blue_v;
    logic [PIX_W-1:0] top_px, mid_px;
    bit hit;
    w = line_len();
    h = frame_rows();
    c = col_pos;
    r = row_pos;
    idx = c % LINE_DEPTH;
    top_px = upper_line[idx];
    mid_px = middle_line[idx];
    upper_line[idx] = mid_px;
    middle_line[idx] = pix;
    for (int k = 0; k < 3; k++) begin
      p[k][0] = win_col[k];
      p[k][1] = win_col[k+3];
    end
    p[0][2] = top_px;
    p[1][2] = mid_px;
    p[2][2] = pix;
    for (int k = 0; k < 3; k++) win_col[k] = win_col[k+3];
    win_col[3] = top_px;
    win_col[4] = mid_px;
    win_col[5] = pix;
    rgb = '0;
    hit = (r >= 2) && (c >= 2) && (r <= h - 1) && (c <= w - 1);
    if (hit) begin
      edge_mean = (p[1][0] + p[1][2] + p[0][1] + p[2][1]) >> 2;
      diag_mean = (p[0][0] + p[0][2] + p[2][0] + p[2][2]) >> 2;
      // site follows the parity of the centre pixel (r-1, c-1)
      case ({(r - 1) % 2 == 1, (c - 1) % 2 == 1})
        2'b11: begin
          red_v = p[1][1];
          green_v = edge_mean;
          blue_v = diag_mean;
        end
        2'b10: begin
          red_v = (p[1][0] + p[1][2]) >> 1;
          green_v = p[1][1];
          blue_v = (p[0][1] + p[2][1]) >> 1;
        end
        2'b01: begin
          red_v = (p[0][1] + p[2][1]) >> 1;
          green_v = p[1][1];
          blue_v = (p[1][0] + p[1][2]) >> 1;
        end
        default: begin
          red_v = diag_mean;
          green_v = edge_mean;
          blue_v = p[1][1];
        end
      endcase
      rgb.blue = blue_v[PIX_W-1:0];
      rgb.green = green_v[PIX_W-1:0];
      rgb.red = red_v[PIX_W-1:0];
      rgb.last = (r == h - 1) && (c == w - 1);
    end
    // counters wrap once they reach or pass the last column / row
    if (c >= w - 1) begin
      col_pos = 0;
      row_pos = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_result(input rgb_t got);
    rgb_t want;
    if (expected_rgb.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: %h", got));
    end else begin
      want = expected_rgb.pop_front();
      if (got.blue !== want.blue)
        report_mismatch($sformatf("blue %0h, expected %0h", got.blue, want.blue));
      if (got.green !== want.green)
        report_mismatch($sformatf("green %0h, expected %0h", got.green, want.green));
      if (got.red !== want.red)
        report_mismatch($sformatf("red %0h, expected %0h", got.red, want.red));
      if (got.last !== want.last)
        report_mismatch($sformatf("frame_last %0b, expected %0b", got.last, want.last));
    end
  endtask

  // result side: sample the transfer, then decide pop for the next edge
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(rgb_t'({blue, green, red, frame_last}));
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                            input rgb_t typed_rgb);
    rgb_t rgb;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    raw_pixel <= pix;
    @(posedge clk);
    while (full) @(posedge clk);
    if (demosaic_pixel(pix, rgb)) expected_rgb = {expected_rgb, (typed ? typed_rgb : rgb)};
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random(input int count);
    repeat (count) begin
      send_pixel(rand_pixel(), 1'b0, NO_RGB);
      random_sent++;
    end
  endtask

  task automatic finish_frame();
    while (col_pos != 0 || row_pos != 0) begin
      send_pixel(rand_pixel(), 1'b0, NO_RGB);
      random_sent++;
    end
  endtask

  // block idle: all results out, then time for samples that give none
  task automatic wait_until_settled();
    push <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    write_size_reg(idx, data);
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w_data,
                           input logic [CFG_DATA_W-1:0] h_data);
    wait_until_settled();
    write_reg(REG_FRAME_WIDTH, w_data);
    write_reg(REG_FRAME_HEIGHT, h_data);
    if ($urandom_range(3) == 0)
      write_reg(CFG_INDEX_W'($urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST)),
                CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // width grows only at a frame start so no line store entry is read unwritten
  task automatic random_phase();
    logic [CFG_DATA_W-1:0] w_data, h_data;
    int unsigned w;
    case ($urandom_range(9))
      0: w = $urandom_range(2);
      1: w = $urandom_range(40, 13);
      default: w = $urandom_range(12, 3);
    endcase
    w_data = CFG_DATA_W'(($urandom_range(3) << FRAME_WIDTH_W) | w);
    h_data = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(2))
                                      : CFG_DATA_W'($urandom_range(8, 3));
    set_frame(w_data, h_data);
    send_random(line_len() * frame_rows() * $urandom_range(2, 1));
    if ($urandom_range(2) == 0) begin
      // shrink the width mid-frame (the height may grow), counters may end up beyond the new size
      send_random($urandom_range(line_len() * frame_rows() - 1, 1));
      w_data = CFG_DATA_W'(($urandom_range(3) << FRAME_WIDTH_W) |
                           $urandom_range(line_len(), 0));
      set_frame(w_data, CFG_DATA_W'($urandom_range(10, 0)));
      finish_frame();
    end
  endtask

  initial begin
    width_reg = FRAME_WIDTH_RESET;
    height_reg = FRAME_HEIGHT_RESET;
    col_pos = 0;
    row_pos = 0;
    foreach (upper_line[k]) begin
      upper_line[k] = '0;
      middle_line[k] = '0;
    end
    foreach (win_col[k]) win_col[k] = '0;
    send_idle_pct = 30;
    recv_idle_pct = 88;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].is_cfg) begin
        wait_until_settled();
        write_reg(DIR_TABLE[i].index, DIR_TABLE[i].data);
        cfg_valid <= 1'b0;
      end else begin
        send_pixel(DIR_TABLE[i].pix, DIR_TABLE[i].typed, DIR_TABLE[i].rgb);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (mode == 0) begin
        // width past the line store saturates: a short probe, then cut short
        // to a 3x3 frame; then the tallest height cut short mid-frame
        set_frame(CFG_DATA_W'(LINE_DEPTH + 3), CFG_DATA_W'(3));
        send_random(SAT_PROBE_ITEMS);
        set_frame(CFG_DATA_W'(3), CFG_DATA_W'(3));
        finish_frame();
        set_frame(CFG_DATA_W'(3), '1);
        send_random(3 * 6);
        set_frame(CFG_DATA_W'(3), CFG_DATA_W'(4));
        finish_frame();
      end
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS_PER_MODE) random_phase();
    end

    push <= 1'b0;
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bbd_pkg.sv
rtl/bbd_queue.sv
rtl/bbd_front.sv
rtl/bbd_back.sv
rtl/bayer_bilinear_demosaic_core.sv
verif/tb_top.sv
